// ----- design/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg: shared types for the button click classifier
// Event codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int unsigned CFG_BITS  = 24;
    localparam int unsigned NOW_BITS  = 48;
    localparam int unsigned IDX_BITS  = 1;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 24'd300000;
    localparam logic [CFG_BITS-1:0] LONG_RESET   = 24'd1000000;

    typedef enum logic [IDX_BITS-1:0] {
        REG_WINDOW = 1'b0,
        REG_LONG   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } click_event_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] window_us;
        logic [CFG_BITS-1:0] long_us;
    } cfg_t;

endpackage

// ----- design/bcc_if.sv -----
// ----------------------------------------------------------------------------
// bcc_tick_if / bcc_event_if: valid/ready channels of the classifier
// One poll sample in, one event word out.
// ----------------------------------------------------------------------------
interface bcc_tick_if;
    logic                         valid;
    logic                         ready;
    logic                         button_pressed;
    logic [bcc_pkg::NOW_BITS-1:0] now_us;

    modport source (output valid, output button_pressed, output now_us, input ready);
    modport sink   (input valid, input button_pressed, input now_us, output ready);
endinterface

interface bcc_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] click_event;

    modport source (output valid, output click_event, input ready);
    modport sink   (input valid, input click_event, output ready);
endinterface

// ----- design/button_click_classifier.sv -----
// ----------------------------------------------------------------------------
// button_click_classifier: single, double and long press detector
//
//   port    dir  payload                    meaning
//   tick    in   button_pressed, now_us     one poll sample
//   click   out  click_event                event of that sample
//   cfg_*   in   cfg_index, cfg_data        window and long-press registers
//
// One word per clock while the result is not stalled, through an input register,
// then the classification logic into the result register.
// Classifier state advances only as a word moves into the result register.
// A stalled result holds its register; the input register still takes a word
// and holds it until the result register frees.
// Reset clears all flags and loads 300000 us window and 1000000 us long press.
// ----------------------------------------------------------------------------
module button_click_classifier #(
    parameter int unsigned TIME_BITS = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bcc_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_BITS-1:0] cfg_data,
    bcc_tick_if.sink                     tick,
    bcc_event_if.source                  click
);

    bcc_pkg::cfg_t         cfg;
    bcc_pkg::click_event_t core_event;

    logic                  in_valid_reg;
    logic                  pressed_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  out_valid_reg;
    logic [1:0]            event_reg;
    logic                  advance;
    logic [63:0]           now_wide;

    // stage control
    assign advance    = in_valid_reg && (!out_valid_reg || click.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign now_wide   = {{(64 - bcc_pkg::NOW_BITS){1'b0}}, tick.now_us};

    // configuration registers
    bcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            pressed_reg <= tick.button_pressed;
            now_reg     <= now_wide[TIME_BITS-1:0];
        end
    end

    // classification
    bcc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .pressed     (pressed_reg),
        .now         (now_reg),
        .cfg         (cfg),
        .click_event (core_event)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (click.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= core_event;
        end
    end

    assign click.valid       = out_valid_reg;
    assign click.click_event = event_reg;

endmodule

// ----- design/bcc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bcc_cfg_regs: configuration register file
// Holds the double-click window and the long-press time.
// ----------------------------------------------------------------------------
module bcc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bcc_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_BITS-1:0] cfg_data,
    output bcc_pkg::cfg_t                cfg
);

    logic [bcc_pkg::CFG_BITS-1:0] window_reg;
    logic [bcc_pkg::CFG_BITS-1:0] long_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= bcc_pkg::WINDOW_RESET;
            long_reg   <= bcc_pkg::LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (bcc_pkg::reg_index_t'(cfg_index))
                bcc_pkg::REG_WINDOW: window_reg <= cfg_data;
                bcc_pkg::REG_LONG:   long_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.window_us = window_reg;
    assign cfg.long_us   = long_reg;

endmodule

// ----- design/bcc_core.sv -----
// ----------------------------------------------------------------------------
// bcc_core: click classification state and next-state logic
// Decides the event of one tick and updates the timing flags.
// ----------------------------------------------------------------------------
module bcc_core #(
    parameter int unsigned TIME_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  pressed,
    input  logic [TIME_BITS-1:0]  now,
    input  bcc_pkg::cfg_t         cfg,
    output bcc_pkg::click_event_t click_event
);

    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] start_next;
    logic                 active_reg;
    logic                 active_next;
    logic                 held_reg;
    logic                 held_next;
    logic                 released_reg;
    logic                 released_next;
    logic                 latched_reg;
    logic                 latched_next;

    logic [63:0]          window_wide;
    logic [63:0]          long_wide;
    logic [TIME_BITS-1:0] window_t;
    logic [TIME_BITS-1:0] long_t;
    logic [TIME_BITS-1:0] elapsed_rel;
    logic [TIME_BITS-1:0] elapsed_press;

    // thresholds at time width
    assign window_wide = {{(64 - bcc_pkg::CFG_BITS){1'b0}}, cfg.window_us};
    assign long_wide   = {{(64 - bcc_pkg::CFG_BITS){1'b0}}, cfg.long_us};
    assign window_t    = window_wide[TIME_BITS-1:0];
    assign long_t      = long_wide[TIME_BITS-1:0];

    // elapsed time, wrapping; a fresh press starts at zero
    assign elapsed_rel   = now - start_reg;
    assign elapsed_press = active_reg ? elapsed_rel : '0;

    // classification
    always_comb
    begin
        start_next    = start_reg;
        active_next   = active_reg;
        held_next     = held_reg;
        released_next = released_reg;
        latched_next  = latched_reg;
        click_event   = bcc_pkg::EV_NONE;

        if (!pressed)
        begin
            if (latched_reg)
            begin
                latched_next = 1'b0;
            end
            else
            begin
                if (held_reg)
                begin
                    held_next     = 1'b0;
                    released_next = 1'b1;
                end
                if (active_reg && (held_reg || released_reg) && elapsed_rel >= window_t)
                begin
                    active_next   = 1'b0;
                    released_next = 1'b0;
                    click_event   = bcc_pkg::EV_SINGLE;
                end
            end
        end
        else if (!latched_reg)
        begin
            if (!active_reg)
            begin
                start_next = now;
            end
            if (active_reg && released_reg && elapsed_press < window_t)
            begin
                active_next   = 1'b0;
                latched_next  = 1'b1;
                released_next = 1'b0;
                click_event   = bcc_pkg::EV_DOUBLE;
            end
            else
            begin
                held_next = 1'b1;
                if (elapsed_press >= long_t)
                begin
                    latched_next  = 1'b1;
                    active_next   = 1'b0;
                    released_next = active_reg ? released_reg : 1'b0;
                    click_event   = bcc_pkg::EV_LONG;
                end
                else
                begin
                    active_next   = 1'b1;
                    released_next = active_reg ? released_reg : 1'b0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= '0;
            active_reg   <= 1'b0;
            held_reg     <= 1'b0;
            released_reg <= 1'b0;
            latched_reg  <= 1'b0;
        end
        else if (step)
        begin
            start_reg    <= start_next;
            active_reg   <= active_next;
            held_reg     <= held_next;
            released_reg <= released_next;
            latched_reg  <= latched_next;
        end
    end

endmodule
